[hdl/dwmt_pkg.sv]
// ----------------------------------------------------------------------------
// dwmt_pkg
// Shared types, widths and the raised-cosine taper table for the
// direct-wave mute block.
// ----------------------------------------------------------------------------
package dwmt_pkg;

  localparam int TAPER_TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TAPER_TABLE_DEPTH);

  localparam int SQ_STEPS = 25;   // one root bit per stage
  localparam int DV_STEPS = 45;   // one quotient bit per stage
  localparam int FRONT_LAT = 5 + SQ_STEPS + DV_STEPS;
  localparam int BACK_LAT = IDX_W + 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [15:0] WEIGHT_ONE = 16'd32768;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [2:0] REG_WAVE_SPEED = 3'd0;
  localparam logic [2:0] REG_SHOT_DEPTH = 3'd1;
  localparam logic [2:0] REG_GEO_DEPTH = 3'd2;
  localparam logic [2:0] REG_EXTRA_DELAY = 3'd3;
  localparam logic [2:0] REG_TAPER_LEN = 3'd4;

  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_TAPER = 2'd1,
    CLS_ONE   = 2'd2
  } cls_t;

  typedef struct packed {
    logic [15:0] wave_speed;
    logic [15:0] shot_depth;
    logic [15:0] geophone_depth;
    logic [23:0] extra_delay;
    logic [23:0] taper_length;
  } cfg_t;

  typedef struct packed {
    cls_t               cls;
    logic [23:0]        diff;
    logic signed [31:0] amp;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [15:0] taper_rom_t [TAPER_TABLE_DEPTH];

  // sin^2 of a quarter wave, Horner Taylor series in Q30, rounded to Q15
  function automatic taper_rom_t build_taper_rom();
    taper_rom_t rom;
    logic [63:0] x, x2, p, s, w;
    for (int i = 0; i < TAPER_TABLE_DEPTH; i++) begin
      x  = (64'(i) * HALF_PI_Q30) / 64'(TAPER_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      p  = Q30_ONE - (((x2 * Q30_ONE) >> 30) / 64'd110);
      p  = Q30_ONE - (((x2 * p) >> 30) / 64'd72);
      p  = Q30_ONE - (((x2 * p) >> 30) / 64'd42);
      p  = Q30_ONE - (((x2 * p) >> 30) / 64'd20);
      p  = Q30_ONE - (((x2 * p) >> 30) / 64'd6);
      s  = (x * p) >> 30;
      if (s > Q30_ONE) s = Q30_ONE;
      w  = (s * s + (64'd1 << 44)) >> 45;
      if (w > 64'(WEIGHT_ONE)) w = 64'(WEIGHT_ONE);
      rom[i] = w[15:0];
    end
    return rom;
  endfunction

  localparam taper_rom_t TAPER_ROM = build_taper_rom();

endpackage

[hdl/dwmt_front.sv]
// ----------------------------------------------------------------------------
// dwmt_front
// Geometry pipeline: offset, squared distance, digit-serial square root,
// travel-time divide, mute-end classification.
// ----------------------------------------------------------------------------
module dwmt_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [23:0]     in_source_x,
  input  logic signed [23:0]     in_receiver_x,
  input  logic [23:0]            in_sample_time,
  input  logic signed [31:0]     in_amplitude,
  input  dwmt_pkg::cfg_t         cfg,
  input  dwmt_pkg::q_stat_t      q_st,
  output dwmt_pkg::push_t        push
);

  logic               en;
  logic               vld_r [dwmt_pkg::FRONT_LAT];
  logic [23:0]        t_r   [dwmt_pkg::FRONT_LAT];
  logic signed [31:0] amp_r [dwmt_pkg::FRONT_LAT];

  assign en = !vld_r[dwmt_pkg::FRONT_LAT-1] || !q_st.full;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < dwmt_pkg::FRONT_LAT; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int j = 1; j < dwmt_pkg::FRONT_LAT; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]   <= in_sample_time;
      amp_r[0] <= in_amplitude;
      for (int j = 1; j < dwmt_pkg::FRONT_LAT; j++) begin
        t_r[j]   <= t_r[j-1];
        amp_r[j] <= amp_r[j-1];
      end
    end
  end

  // offsets
  logic signed [24:0] dx;
  logic signed [16:0] dz;
  logic [24:0]        adx_r;
  logic [15:0]        adz_r;

  assign dx = 25'(in_receiver_x) - 25'(in_source_x);
  assign dz = 17'(signed'({1'b0, cfg.geophone_depth})) -
              17'(signed'({1'b0, cfg.shot_depth}));

  always_ff @(posedge clk) begin
    if (en) begin
      adx_r <= dx[24] ? 25'(~dx + 25'd1) : 25'(dx);
      adz_r <= dz[16] ? 16'(~dz + 17'd1) : dz[15:0];
    end
  end

  // squared distance
  logic [49:0] n_r;
  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= 50'(adx_r) * 50'(adx_r) + 50'(adz_r) * 50'(adz_r);
    end
  end

  // square root, two radicand bits per stage
  logic [25:0] sq_rem_r  [dwmt_pkg::SQ_STEPS];
  logic [24:0] sq_root_r [dwmt_pkg::SQ_STEPS];
  logic [49:0] sq_n_r    [dwmt_pkg::SQ_STEPS];

  genvar k;
  for (k = 0; k < dwmt_pkg::SQ_STEPS; k++) begin : g_sq
    logic [25:0] rem_i;
    logic [24:0] root_i;
    logic [49:0] n_i;
    logic [27:0] r;
    logic [27:0] trial;
    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign n_i    = n_r;
    end else begin : g_next
      assign rem_i  = sq_rem_r[k-1];
      assign root_i = sq_root_r[k-1];
      assign n_i    = sq_n_r[k-1];
    end
    assign r     = {rem_i, n_i[49:48]};
    assign trial = {1'b0, root_i, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (r >= trial) begin
          sq_rem_r[k]  <= 26'(r - trial);
          sq_root_r[k] <= {root_i[23:0], 1'b1};
        end else begin
          sq_rem_r[k]  <= r[25:0];
          sq_root_r[k] <= {root_i[23:0], 1'b0};
        end
        sq_n_r[k] <= {n_i[47:0], 2'b00};
      end
    end
  end

  // round to nearest metre, then scale to microsecond-metres
  logic [24:0] dist_r;
  logic [44:0] dvd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= sq_root_r[dwmt_pkg::SQ_STEPS-1] +
                25'(sq_rem_r[dwmt_pkg::SQ_STEPS-1] >
                    {1'b0, sq_root_r[dwmt_pkg::SQ_STEPS-1]});
      dvd_r  <= 45'(dist_r) * 45'(dwmt_pkg::USEC_PER_SEC);
    end
  end

  // divide by wave speed, one quotient bit per stage
  logic [15:0] spd;
  logic [15:0] dv_rem_r [dwmt_pkg::DV_STEPS];
  logic [44:0] dv_q_r   [dwmt_pkg::DV_STEPS];
  logic [44:0] dv_n_r   [dwmt_pkg::DV_STEPS];

  assign spd = (cfg.wave_speed == '0) ? 16'd1 : cfg.wave_speed;

  for (k = 0; k < dwmt_pkg::DV_STEPS; k++) begin : g_dv
    logic [15:0] rem_i;
    logic [44:0] q_i;
    logic [44:0] n_i;
    logic [16:0] r;
    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign q_i   = '0;
      assign n_i   = dvd_r;
    end else begin : g_next
      assign rem_i = dv_rem_r[k-1];
      assign q_i   = dv_q_r[k-1];
      assign n_i   = dv_n_r[k-1];
    end
    assign r = {rem_i, n_i[44]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (r >= {1'b0, spd}) begin
          dv_rem_r[k] <= 16'(r - {1'b0, spd});
          dv_q_r[k]   <= {q_i[43:0], 1'b1};
        end else begin
          dv_rem_r[k] <= r[15:0];
          dv_q_r[k]   <= {q_i[43:0], 1'b0};
        end
        dv_n_r[k] <= {n_i[43:0], 1'b0};
      end
    end
  end

  // classify against the mute end and taper window
  logic [45:0]        arr_end;
  logic [46:0]        win_end;
  logic [23:0]        t_cls;
  dwmt_pkg::cls_t     cls_nxt;
  dwmt_pkg::cls_t     cls_r;
  logic [23:0]        diff_r;

  assign t_cls   = t_r[dwmt_pkg::FRONT_LAT-2];
  assign arr_end = 46'(dv_q_r[dwmt_pkg::DV_STEPS-1]) + 46'(cfg.extra_delay);
  assign win_end = 47'(arr_end) + 47'(cfg.taper_length);

  always_comb begin
    if (46'(t_cls) <= arr_end) begin
      cls_nxt = dwmt_pkg::CLS_ZERO;
    end else if (cfg.taper_length != '0 && 47'(t_cls) < win_end) begin
      cls_nxt = dwmt_pkg::CLS_TAPER;
    end else begin
      cls_nxt = dwmt_pkg::CLS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r  <= cls_nxt;
      diff_r <= 24'(46'(t_cls) - arr_end);
    end
  end

  assign push.valid     = vld_r[dwmt_pkg::FRONT_LAT-1] && !q_st.full;
  assign push.item.cls  = cls_r;
  assign push.item.diff = diff_r;
  assign push.item.amp  = amp_r[dwmt_pkg::FRONT_LAT-1];

endmodule

[hdl/dwmt_queue.sv]
// ----------------------------------------------------------------------------
// dwmt_queue
// Short FIFO between the geometry front and the weighting back.
// ----------------------------------------------------------------------------
module dwmt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  dwmt_pkg::push_t   push,
  input  logic              pop,
  output dwmt_pkg::q_stat_t q_st,
  output dwmt_pkg::item_t   q_item
);

  dwmt_pkg::item_t            mem_r [dwmt_pkg::QUEUE_DEPTH];
  logic [dwmt_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [dwmt_pkg::QPTR_W:0]   cnt_r;

  assign q_st.full  = (cnt_r == (dwmt_pkg::QPTR_W+1)'(dwmt_pkg::QUEUE_DEPTH));
  assign q_st.empty = (cnt_r == '0);
  assign q_item     = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.valid) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      if (push.valid && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push.valid && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_r] <= push.item;
  end

endmodule

[hdl/dwmt_back.sv]
// ----------------------------------------------------------------------------
// dwmt_back
// Weighting pipeline: taper index divide, table lookup, multiply,
// round and saturate into the output register.
// ----------------------------------------------------------------------------
module dwmt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dwmt_pkg::q_stat_t   q_st,
  input  dwmt_pkg::item_t     q_item,
  output logic                pop,
  input  logic [23:0]         taper_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_muted_amplitude,
  output logic [15:0]         out_taper_weight
);

  localparam int IW = dwmt_pkg::IDX_W;
  localparam int BL = dwmt_pkg::BACK_LAT;

  logic               en;
  logic               vld_r [BL];
  dwmt_pkg::cls_t     cls_r [BL];
  logic signed [31:0] amp_r [BL];

  assign en  = !out_valid || !out_stall;
  assign pop = en && !q_st.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < BL; j++) vld_r[j] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !q_st.empty;
      for (int j = 1; j < BL; j++) vld_r[j] <= vld_r[j-1];
      out_valid <= vld_r[BL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r[0] <= q_item.cls;
      amp_r[0] <= q_item.amp;
      for (int j = 1; j < BL; j++) begin
        cls_r[j] <= cls_r[j-1];
        amp_r[j] <= amp_r[j-1];
      end
    end
  end

  // offset into window scaled by table depth
  logic [23+IW:0] dvd_r;
  always_ff @(posedge clk) begin
    if (en) dvd_r <= (24+IW)'(q_item.diff) * (24+IW)'(dwmt_pkg::TAPER_TABLE_DEPTH);
  end

  // quotient is below the table depth, so only IW bits are developed
  logic [23:0]   dv_rem_r [IW];
  logic [IW-1:0] dv_q_r   [IW];
  logic [IW-1:0] dv_n_r   [IW];

  genvar k;
  for (k = 0; k < IW; k++) begin : g_dv
    logic [23:0]   rem_i;
    logic [IW-1:0] q_i;
    logic [IW-1:0] n_i;
    logic [24:0]   r;
    if (k == 0) begin : g_first
      assign rem_i = dvd_r[23+IW:IW];
      assign q_i   = '0;
      assign n_i   = dvd_r[IW-1:0];
    end else begin : g_next
      assign rem_i = dv_rem_r[k-1];
      assign q_i   = dv_q_r[k-1];
      assign n_i   = dv_n_r[k-1];
    end
    assign r = {rem_i, n_i[IW-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (r >= {1'b0, taper_length}) begin
          dv_rem_r[k] <= 24'(r - {1'b0, taper_length});
          dv_q_r[k]   <= {q_i[IW-2:0], 1'b1};
        end else begin
          dv_rem_r[k] <= r[23:0];
          dv_q_r[k]   <= {q_i[IW-2:0], 1'b0};
        end
        dv_n_r[k] <= {n_i[IW-2:0], 1'b0};
      end
    end
  end

  // weight select
  logic [IW-1:0] idx;
  logic [15:0]   wt_nxt;
  logic [15:0]   wt_r, wt2_r;

  always_comb begin
    idx = dv_q_r[IW-1];
    if (32'(idx) >= dwmt_pkg::TAPER_TABLE_DEPTH) idx = IW'(dwmt_pkg::TAPER_TABLE_DEPTH - 1);
    case (cls_r[IW])
      dwmt_pkg::CLS_ZERO:  wt_nxt = '0;
      dwmt_pkg::CLS_TAPER: wt_nxt = dwmt_pkg::TAPER_ROM[idx];
      dwmt_pkg::CLS_ONE:   wt_nxt = dwmt_pkg::WEIGHT_ONE;
      default:             wt_nxt = '0;
    endcase
  end

  // multiply, then round half up and saturate
  logic signed [48:0] prod_r;
  logic signed [49:0] sum;
  logic signed [34:0] sh;
  logic signed [31:0] sat;

  assign sum = 50'(prod_r) + 50'sd16384;
  assign sh  = 35'(sum >>> 15);

  always_comb begin
    if (sh > 35'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sh < -35'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wt_r   <= wt_nxt;
      prod_r <= 49'(amp_r[IW+1]) * 49'(signed'({1'b0, wt_r}));
      wt2_r  <= wt_r;
      out_muted_amplitude <= sat;
      out_taper_weight    <= wt2_r;
    end
  end

endmodule

[hdl/direct_wave_mute_taper.sv]
// ----------------------------------------------------------------------------
// direct_wave_mute_taper
// Direct-arrival mute with raised-cosine taper on a stream of trace samples.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   in_      | in_valid / in_stall  | source_x, receiver_x, sample_time,
//            |                      | amplitude
//   out_     | out_valid/out_stall  | muted_amplitude, taper_weight
//   cfg_     | cfg_we               | cfg_index, cfg_wdata
//
// One sample per clock sustained while no stall holds the flow. Delay through
// the block comes from the 25-stage square root and the 45-stage travel-time
// divider in the front, the queue, and the 8-stage taper-index divider plus
// lookup, multiply and rounding in the back.
// Reset is synchronous; no clearing pass, the taper table is a constant.
// An output stall freezes the back only; the front keeps going until the
// 4-entry queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
module direct_wave_mute_taper (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_source_x,
  input  logic signed [23:0] in_receiver_x,
  input  logic [23:0]        in_sample_time,
  input  logic signed [31:0] in_amplitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_muted_amplitude,
  output logic [15:0]        out_taper_weight
);

  dwmt_pkg::cfg_t    cfg_r;
  dwmt_pkg::push_t   push;
  dwmt_pkg::q_stat_t q_st;
  dwmt_pkg::item_t   q_item;
  logic              pop;

  // config registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_speed     <= 16'd1500;
      cfg_r.shot_depth     <= 16'd0;
      cfg_r.geophone_depth <= 16'd0;
      cfg_r.extra_delay    <= 24'd80000;
      cfg_r.taper_length   <= 24'd40000;
    end else if (cfg_we) begin
      case (cfg_index)
        dwmt_pkg::REG_WAVE_SPEED:  cfg_r.wave_speed     <= cfg_wdata[15:0];
        dwmt_pkg::REG_SHOT_DEPTH:  cfg_r.shot_depth     <= cfg_wdata[15:0];
        dwmt_pkg::REG_GEO_DEPTH:   cfg_r.geophone_depth <= cfg_wdata[15:0];
        dwmt_pkg::REG_EXTRA_DELAY: cfg_r.extra_delay    <= cfg_wdata;
        dwmt_pkg::REG_TAPER_LEN:   cfg_r.taper_length   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: geometry and classification
  dwmt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_source_x   (in_source_x),
    .in_receiver_x (in_receiver_x),
    .in_sample_time(in_sample_time),
    .in_amplitude  (in_amplitude),
    .cfg           (cfg_r),
    .q_st          (q_st),
    .push          (push)
  );

  // decoupling queue
  dwmt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .q_st  (q_st),
    .q_item(q_item)
  );

  // back: taper weight and scaling
  dwmt_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_st               (q_st),
    .q_item             (q_item),
    .pop                (pop),
    .taper_length       (cfg_r.taper_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_muted_amplitude(out_muted_amplitude),
    .out_taper_weight   (out_taper_weight)
  );

`ifndef NO_ASSERTIONS
  // weight never above one
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_taper_weight <= 16'd32768)
    else $error("taper weight above one");

  // muted samples come out as zero
  a_zero_mute: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_taper_weight == 16'd0) |-> out_muted_amplitude == 32'sd0)
    else $error("nonzero amplitude under full mute");

  // no transfer into a full queue, no pop from an empty one
  a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && q_st.full) && !(pop && q_st.empty))
    else $error("queue overflow or underflow");
`endif

endmodule

[bench/direct_wave_mute_taper_tb.sv]
// ----------------------------------------------------------------------------
// direct_wave_mute_taper_tb
// Self-checking bench for the direct-wave mute: directed corner samples and
// random streams under several register settings, checked against an
// in-bench fixed-point mute predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module direct_wave_mute_taper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] muted_amplitude;
    logic [15:0]        taper_weight;
  } mute_result_t;

  // Scoreboard: holds the predicted mute results in transfer order.
  class mute_scoreboard;
    mute_result_t pending[$];
    int           errors;

    function void note_sample(mute_result_t r);
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] amp, logic [15:0] wgt);
      mute_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: muted_amplitude %0d taper_weight %0d", amp, wgt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (amp !== e.muted_amplitude) begin
        $error("muted_amplitude expected %0d actual %0d", e.muted_amplitude, amp);
        errors++;
      end
      if (wgt !== e.taper_weight) begin
        $error("taper_weight expected %0d actual %0d", e.taper_weight, wgt);
        errors++;
      end
    endfunction
  endclass

  // index past the register list, writes to it are dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = dwmt_pkg::REG_WAVE_SPEED;
  logic [23:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_source_x = '0;
  logic signed [23:0] in_receiver_x = '0;
  logic [23:0] in_sample_time = '0;
  logic signed [31:0] in_amplitude = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_muted_amplitude;
  logic [15:0] out_taper_weight;

  direct_wave_mute_taper dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  mute_scoreboard sb = new();
  dwmt_pkg::cfg_t shadow_cfg;
  logic [15:0] weight_rom [dwmt_pkg::TAPER_TABLE_DEPTH];

  bit idle_free = 1'b0;     // last part of the run: no idling
  bit hold_output = 1'b0;   // long receiver hold-off request
  int cycle_count = 0;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT = dwmt_pkg::FRONT_LAT + dwmt_pkg::BACK_LAT +
                              dwmt_pkg::QUEUE_DEPTH + 20;

  // Quarter-wave sin^2 table, rebuilt here from the Horner series.
  function automatic logic [15:0] sine_sq(int i);
    logic [63:0] x, x2, p, s, w;
    int          k[5] = '{110, 72, 42, 20, 6};
    x  = (64'(i) * 64'd1686629713) / 64'(dwmt_pkg::TAPER_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    p  = 64'd1 << 30;
    foreach (k[j]) p = (64'd1 << 30) - (((x2 * p) >> 30) / 64'(k[j]));
    s = (x * p) >> 30;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    w = (s * s + (64'd1 << 44)) >> 45;
    if (w > 64'd32768) w = 64'd32768;
    return w[15:0];
  endfunction

  function automatic logic [63:0] root_round(logic [63:0] n);
    logic [63:0] res, bitv, rem;
    res = 0; bitv = 64'd1 << 62; rem = n;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (rem > res) res += 1;
    return res;
  endfunction

  function automatic mute_result_t predict_mute(logic signed [23:0] sx,
      logic signed [23:0] rx, logic [23:0] t, logic signed [31:0] amp);
    mute_result_t r;
    longint dx, dz, prod, rnd;
    logic [63:0] dist_m, speed, arr_end, idx, w;
    dx = longint'(rx) - longint'(sx);
    dz = longint'(shadow_cfg.geophone_depth) - longint'(shadow_cfg.shot_depth);
    if (dx < 0) dx = -dx;
    if (dz < 0) dz = -dz;
    dist_m = root_round(64'(dx * dx + dz * dz));
    speed  = (shadow_cfg.wave_speed == 0) ? 64'd1 : 64'(shadow_cfg.wave_speed);
    arr_end = (dist_m * 64'd1000000) / speed + 64'(shadow_cfg.extra_delay);
    if (64'(t) <= arr_end) w = 0;
    else if (shadow_cfg.taper_length != 0 &&
             64'(t) < arr_end + 64'(shadow_cfg.taper_length)) begin
      idx = ((64'(t) - arr_end) * dwmt_pkg::TAPER_TABLE_DEPTH) /
            64'(shadow_cfg.taper_length);
      if (idx >= dwmt_pkg::TAPER_TABLE_DEPTH) idx = dwmt_pkg::TAPER_TABLE_DEPTH - 1;
      w = 64'(weight_rom[idx]);
    end else w = 64'd32768;
    prod = longint'(amp) * longint'(w);
    rnd  = (prod + 16384) >>> 15;     // floor(x + 0.5)
    if (rnd > 64'sd2147483647) rnd = 64'sd2147483647;
    if (rnd < -64'sd2147483648) rnd = -64'sd2147483648;
    r.muted_amplitude = rnd[31:0];
    r.taper_weight    = w[15:0];
    return r;
  endfunction

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      dwmt_pkg::REG_WAVE_SPEED:  shadow_cfg.wave_speed     = val[15:0];
      dwmt_pkg::REG_SHOT_DEPTH:  shadow_cfg.shot_depth     = val[15:0];
      dwmt_pkg::REG_GEO_DEPTH:   shadow_cfg.geophone_depth = val[15:0];
      dwmt_pkg::REG_EXTRA_DELAY: shadow_cfg.extra_delay    = val;
      dwmt_pkg::REG_TAPER_LEN:   shadow_cfg.taper_length   = val;
      default: ;     // out-of-range index: ignored
    endcase
  endtask

  task automatic program_all(logic [15:0] ws, logic [15:0] sd, logic [15:0] gd,
                             logic [23:0] ed, logic [23:0] tl);
    write_reg(dwmt_pkg::REG_WAVE_SPEED, 24'(ws));
    write_reg(dwmt_pkg::REG_SHOT_DEPTH, 24'(sd));
    write_reg(dwmt_pkg::REG_GEO_DEPTH, 24'(gd));
    write_reg(dwmt_pkg::REG_EXTRA_DELAY, ed);
    write_reg(dwmt_pkg::REG_TAPER_LEN, tl);
    cfg_we <= 1'b0;
  endtask

  // Block must be empty before any register write.
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Drive one sample; hold it until the transfer completes.
  task automatic send_sample(logic signed [23:0] sx, logic signed [23:0] rx,
                             logic [23:0] t, logic signed [31:0] amp);
    if (!idle_free && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_source_x   <= sx;
    in_receiver_x <= rx;
    in_sample_time <= t;
    in_amplitude  <= amp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(predict_mute(sx, rx, t, amp));
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random sample aimed around the mute edge and taper window most of the time.
  task automatic send_random();
    logic signed [23:0] sx, rx;
    logic [23:0] t;
    logic signed [31:0] amp;
    longint      edge_t;
    sx = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($signed($urandom_range(0, 4000)) - 2000);
    rx = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($signed($urandom_range(0, 4000)) - 2000);
    // rough mute end from horizontal offset only
    edge_t = longint'(shadow_cfg.extra_delay) +
             ((longint'(rx) - longint'(sx)) < 0 ? -(longint'(rx) - longint'(sx))
                                                  : (longint'(rx) - longint'(sx))) *
             1000000 / (shadow_cfg.wave_speed == 0 ? 1 : shadow_cfg.wave_speed);
    if ($urandom_range(0, 4) == 0 || edge_t > 24'hFF0000)
      t = 24'($urandom);
    else
      t = 24'(edge_t + $urandom_range(0, 2 * shadow_cfg.taper_length + 200) - 100);
    case ($urandom_range(0, 3))
      0: amp = 32'h7FFFFFFF;
      1: amp = 32'h80000000;
      default: amp = $urandom;
    endcase
    send_sample(sx, rx, t, amp);
  endtask

  // Receiver: random stall bursts, long hold-off when requested.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
        for (n = 0; n < 300; n++) @(posedge clk);
        hold_output = 1'b0;
        out_stall <= 1'b0;
      end else if (!idle_free && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor: check every completed out_ transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_muted_amplitude, out_taper_weight);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < dwmt_pkg::TAPER_TABLE_DEPTH; i++) weight_rom[i] = sine_sq(i);
    shadow_cfg = '{wave_speed: 16'd1500, shot_depth: 16'd0, geophone_depth: 16'd0,
                   extra_delay: 24'd80000, taper_length: 24'd40000};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: before, at, inside and after the taper.
    send_sample(24'sd0, 24'sd1500, 24'd0, 32'sh7FFFFFFF);
    send_sample(24'sd0, 24'sd1500, 24'd1080000, 32'sh7FFFFFFF);      // at mute end
    send_sample(24'sd0, 24'sd1500, 24'd1080001, 32'sh7FFFFFFF);
    send_sample(24'sd0, 24'sd1500, 24'd1100000, -32'sd2147483648);
    send_sample(24'sd0, 24'sd1500, 24'd1119999, 32'sh7FFFFFFF);
    send_sample(24'sd0, 24'sd1500, 24'd1120000, -32'sd2147483648);  // past window
    send_sample(-24'sd8388608, 24'sd8388607, 24'hFFFFFF, 32'sd12345);
    send_sample(24'sd8388607, -24'sd8388608, 24'd0, -32'sd1);
    send_sample(24'sd0, 24'sd0, 24'hFFFFFF, -32'sd1);
    send_sample(24'sd0, 24'sd0, 24'd80001, 32'sd1);
    end_burst();
    wait_idle();

    // Hard mute, zero speed, depth offsets, out-of-range index.
    program_all(16'd0, 16'hFFFF, 16'd0, 24'd0, 24'd0);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    cfg_we <= 1'b0;
    send_sample(24'sd0, 24'sd0, 24'hFFFFFF, 32'sh7FFFFFFF);
    send_sample(24'sd5, 24'sd5, 24'd1, 32'sh7FFFFFFF);
    end_burst();
    wait_idle();
    program_all(16'hFFFF, 16'd0, 16'hFFFF, 24'd0, 24'd1);
    send_sample(24'sd0, 24'sd0, 24'd1000000, 32'sd100);
    send_sample(24'sd0, 24'sd0, 24'd1000001, 32'sd100);
    send_sample(24'sd0, 24'sd0, 24'd1000002, -32'sd100);
    end_burst();
    wait_idle();

    // Random phases over several settings.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: program_all(16'd1500, 16'd0, 16'd0, 24'd80000, 24'd40000);
        1: program_all(16'd2000, 16'd100, 16'd1500, 24'd0, 24'd255);
        2: program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        3: program_all(16'd3000, 16'd500, 16'd20, 24'd1000, 24'd0);
        default: program_all(16'($urandom_range(300, 6000)), 16'($urandom),
                             16'($urandom), 24'($urandom_range(0, 200000)),
                             24'($urandom_range(1, 100000)));
      endcase
      if (ph == 4) idle_free = 1'b1;
      if (ph == 1) hold_output = 1'b1;     // fill the queue, force in_stall
      for (i = 0; i < 110; i++) send_random();
      if (ph == 0) begin
        // sender pauses until everything has drained
        end_burst();
        while (sb.pending.size() != 0) @(posedge clk);
      end
      end_burst();
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
